// ===== sv/sorted_list_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted list engine assertion macros
// Shared macros for the concurrent checks of the sorted list engine.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_TOP_ASSERT_SVH
`define SORTED_LIST_ENGINE_TOP_ASSERT_SVH

// Check that holds outside reset, sampled on clk.
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds on every edge, reset included.
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine package
// Sizes, operation and status codes, and the link type between cells.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ELEM_W   = 32;
  localparam int TOTAL_W  = 6;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;
  localparam int OUT_W    = 48;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LIST   = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd6;

  // per-cell commands
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_REMOVE = 2'd2;
  localparam logic [1:0] CELL_ROTATE = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic signed [ELEM_W-1:0] elem;
  } link_t;

endpackage

// ===== sv/sle_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine cell
// Holds one list entry; shifts right on insert, left on remove, rotates on list.
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [1:0]                       op,
  input  logic signed [sle_pkg::ELEM_W-1:0] value,
  input  logic signed [sle_pkg::ELEM_W-1:0] head_elem,
  input  sle_pkg::link_t                   left_link,
  input  logic                             left_gt,
  input  sle_pkg::link_t                   right_link,
  output sle_pkg::link_t                   link,
  output logic                             gt,
  output logic                             match
);
  import sle_pkg::*;

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [ELEM_W-1:0] elem_r;
  logic signed [ELEM_W-1:0] elem_nxt;

  assign gt    = valid_r && (value > elem_r);
  assign match = valid_r && (value == elem_r);
  assign link  = '{valid: valid_r, elem: elem_r};

  always_comb begin
    elem_nxt  = elem_r;
    valid_nxt = valid_r;
    case (op)
      CELL_INSERT: begin
        // first cell not below the value takes it, cells after it take the left entry
        if (!gt) begin
          elem_nxt = left_gt ? value : left_link.elem;
        end
        valid_nxt = valid_r | left_link.valid;
      end
      CELL_REMOVE: begin
        // match is known present: everything from the first match on moves left
        if (valid_r && !gt) begin
          elem_nxt  = right_link.elem;
          valid_nxt = right_link.valid;
        end
      end
      CELL_ROTATE: begin
        if (valid_r) begin
          elem_nxt = right_link.valid ? right_link.elem : head_elem;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

endmodule

// ===== sv/sorted_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine
// Ascending store of signed values in a row of cells: insert, remove, search, list.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_*     slave      tuser = kind, tdata = value
//  out_*    master     tdata = status, element, entry_total; tlast = last
//
//  Insert, remove and search register the item, then every cell compares
//  against the value in parallel and shifts.
//  List rotates the row one entry per result.
//  Output stalls hold the execute and list steps until the result register frees.
//  Reset clears the entry count and the cell valid bits; no clearing pass.
`include "sorted_list_engine_top_assert.svh"

module sorted_list_engine_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tuser,   // [1:0] kind
  input  logic [31:0]                 in_tdata,   // [31:0] value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sle_pkg::OUT_W-1:0]   out_tdata,  // [2:0] status, [34:3] element,
                                                  // [40:35] entry_total
  output logic                        out_tlast
);
  import sle_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [KIND_W-1:0]        kind_r;
  logic signed [ELEM_W-1:0] value_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         list_left_r, list_left_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic signed [ELEM_W-1:0] out_elem_r, out_elem_nxt;
  logic [TOTAL_W-1:0]       out_total_r, out_total_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [1:0]               cell_op;
  link_t                    cell_link [CAPACITY];
  logic [CAPACITY-1:0]      gt_vec;
  logic [CAPACITY-1:0]      match_vec;
  logic                     found;
  logic                     slot_free;
  logic                     in_xfer;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign found      = |match_vec;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_W - STATUS_W - ELEM_W - TOTAL_W){1'b0}},
                       out_total_r, out_elem_r, out_status_r};

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t left_l;
    link_t right_l;
    logic  left_g;
    if (i == 0) begin : g_first
      assign left_l = '{valid: 1'b1, elem: value_r};
      assign left_g = 1'b1;
    end else begin : g_mid
      assign left_l = cell_link[i-1];
      assign left_g = gt_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_l = '{valid: 1'b0, elem: cell_link[0].elem};
    end else begin : g_inner
      assign right_l = cell_link[i+1];
    end
    sle_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (cell_op),
      .value      (value_r),
      .head_elem  (cell_link[0].elem),
      .left_link  (left_l),
      .left_gt    (left_g),
      .right_link (right_l),
      .link       (cell_link[i]),
      .gt         (gt_vec[i]),
      .match      (match_vec[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    list_left_nxt  = list_left_r;
    cell_op        = CELL_HOLD;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_total_nxt  = out_total_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_elem_nxt   = value_r;
          out_total_nxt  = TOTAL_W'(count_r);
          case (kind_r)
            KIND_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
              end else begin
                cell_op        = CELL_INSERT;
                count_nxt      = count_r + CNT_W'(1);
                out_status_nxt = ST_INSERTED;
                out_total_nxt  = TOTAL_W'(count_r + CNT_W'(1));
              end
            end
            KIND_REMOVE, KIND_SEARCH: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (!found) begin
                out_status_nxt = ST_NOT_FOUND;
              end else if (kind_r == KIND_SEARCH) begin
                out_status_nxt = ST_FOUND;
              end else begin
                cell_op        = CELL_REMOVE;
                count_nxt      = count_r - CNT_W'(1);
                out_status_nxt = ST_REMOVED;
                out_total_nxt  = TOTAL_W'(count_r - CNT_W'(1));
              end
            end
            default: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
                out_elem_nxt   = '0;
              end else begin
                // nothing sent yet; the list step emits every entry
                out_valid_nxt = out_valid_r && !out_tready;
                list_left_nxt = count_r;
                state_nxt     = S_LIST;
              end
            end
          endcase
        end
      end
      S_LIST: begin
        if (slot_free) begin
          cell_op        = CELL_ROTATE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_LISTED;
          out_elem_nxt   = cell_link[0].elem;
          out_total_nxt  = TOTAL_W'(count_r);
          out_last_nxt   = (list_left_r == CNT_W'(1));
          list_left_nxt  = list_left_r - CNT_W'(1);
          if (list_left_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      list_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_left_r <= list_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= in_tuser[KIND_W-1:0];
      value_r <= in_tdata[ELEM_W-1:0];
    end
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_total_r  <= out_total_nxt;
    out_last_r   <= out_last_nxt;
  end

  `SLE_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> (!out_tvalid && in_tready), "not idle after reset")
  `SLE_ASSERT(a_count_bound, (count_r <= CNT_W'(CAPACITY)), "entry count above capacity")
  `SLE_ASSERT(a_accept_exec, (in_tvalid && in_tready) |=> (state_r == S_EXEC), "accepted item not executed")
  `SLE_ASSERT(a_list_done, (state_r == S_LIST && slot_free && list_left_r == CNT_W'(1)) |=> (state_r == S_IDLE && out_last_r), "list did not end on last entry")
  `SLE_ASSERT(a_count_step, (cell_op == CELL_HOLD || cell_op == CELL_ROTATE) |=> (count_r == $past(count_r)), "count changed without insert or remove")

endmodule
